// ===== design/dpt_pkg.sv =====
// Shared types, constants and digit helpers for the differential phase trip unit.
// No dependencies; imported by dpt_lane, dpt_ctrl and differential_phase_trip_unit.
package dpt_pkg;

  localparam int NUM_PHASES = 3;
  localparam int SAMPLE_W   = 10;
  localparam int SUM_W      = 12;
  localparam int DIGIT_W    = 8;
  localparam int ARM_W      = 2;
  localparam int PHASE_W    = 2;

  localparam logic [ARM_W-1:0]   ARM_MAX    = 2'd3;
  localparam logic [ARM_W-1:0]   ARM_RESET  = 2'd2;
  localparam logic [DIGIT_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [DIGIT_W-1:0] HDR_R      = 8'h61;
  localparam logic [DIGIT_W-1:0] HDR_Y      = 8'h62;
  localparam logic [DIGIT_W-1:0] HDR_B      = 8'h64;

  // reciprocal of 3: floor(s * 2731 / 8192) == s / 3 for s < 3072
  localparam logic [SUM_W:0] RECIP_THREE = 13'd2731;
  localparam int             RECIP_SHIFT = 13;

  localparam logic [PHASE_W-1:0] PHASE_NONE = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_R    = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_Y    = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_B    = 2'd3;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_SERIAL  = 1'b1;

  typedef enum logic [3:0] {
    TGT_IDLE = 4'b0001,
    TGT_R    = 4'b0010,
    TGT_Y    = 4'b0100,
    TGT_B    = 4'b1000
  } rx_target_t;

  typedef struct packed {
    logic                mismatch;
    logic [SAMPLE_W-1:0] avg;
  } lane_res_t;

  typedef struct packed {
    logic                tripped;
    logic [PHASE_W-1:0]  phase;
    logic                indicator;
    logic [SAMPLE_W-1:0] r_avg;
    logic [SAMPLE_W-1:0] y_avg;
    logic [SAMPLE_W-1:0] b_avg;
  } status_t;

  function automatic logic [DIGIT_W-1:0] lead_digit(input logic [SAMPLE_W-1:0] avg);
    lead_digit = (avg >= 10'd1000) ? ASCII_ZERO + 8'd1 : ASCII_ZERO;
  endfunction

  function automatic logic [DIGIT_W-1:0] hundreds_digit(input logic [SAMPLE_W-1:0] avg);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if (avg >= SAMPLE_W'(k * 100)) q = 4'(k);
    end
    if (q == 4'd10) q = 4'd0;
    hundreds_digit = ASCII_ZERO + {4'd0, q};
  endfunction

endpackage

// ===== design/dpt_lane.sv =====
// One phase lane: average of three samples, local digits, compare with remote digits.
// Depends on dpt_pkg.
module dpt_lane (
  input  logic [dpt_pkg::SAMPLE_W-1:0] sample_one,
  input  logic [dpt_pkg::SAMPLE_W-1:0] sample_two,
  input  logic [dpt_pkg::SAMPLE_W-1:0] sample_three,
  input  logic [dpt_pkg::DIGIT_W-1:0]  remote_lead,
  input  logic [dpt_pkg::DIGIT_W-1:0]  remote_hundreds,
  output dpt_pkg::lane_res_t           res
);
  import dpt_pkg::*;

  logic [SUM_W-1:0]       sum;
  logic [2*SUM_W:0]       prod;
  logic [SAMPLE_W-1:0]    avg;

  assign sum  = SUM_W'(sample_one) + SUM_W'(sample_two) + SUM_W'(sample_three);
  assign prod = (2*SUM_W+1)'(sum) * (2*SUM_W+1)'(RECIP_THREE);
  assign avg  = prod[RECIP_SHIFT +: SAMPLE_W];

  assign res.avg      = avg;
  assign res.mismatch = (remote_lead != lead_digit(avg)) ||
                        (remote_hundreds != hundreds_digit(avg));

endmodule

// ===== design/dpt_ctrl.sv =====
// Frame parser, arming counter, trip latch and lane merge.
// Depends on dpt_pkg; fed by the three dpt_lane instances.
module dpt_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        kind,
  input  logic [dpt_pkg::DIGIT_W-1:0] rx_byte,
  input  dpt_pkg::lane_res_t          lane_res [dpt_pkg::NUM_PHASES],
  input  logic                        cfg_we,
  input  logic [dpt_pkg::ARM_W-1:0]   cfg_arm_frames,
  output logic [dpt_pkg::DIGIT_W-1:0] remote_lead [dpt_pkg::NUM_PHASES],
  output logic [dpt_pkg::DIGIT_W-1:0] remote_hundreds [dpt_pkg::NUM_PHASES],
  output dpt_pkg::status_t            status
);
  import dpt_pkg::*;

  logic [ARM_W-1:0]    arm_frames;
  logic [ARM_W-1:0]    arm_counter;
  rx_target_t          rx_target;
  logic [1:0]          rx_position;
  logic                trip_latch;
  logic [PHASE_W-1:0]  trip_phase;
  logic                indicator_flag;
  logic [SAMPLE_W-1:0] last_avg [NUM_PHASES];

  logic [PHASE_W-1:0]  hit_phase;
  logic [1:0]          tgt_idx;

  // R over Y over B
  always_comb begin
    hit_phase = PHASE_NONE;
    if (lane_res[0].mismatch) hit_phase = PHASE_R;
    else if (lane_res[1].mismatch) hit_phase = PHASE_Y;
    else if (lane_res[2].mismatch) hit_phase = PHASE_B;
  end

  always_comb begin
    unique case (rx_target)
      TGT_R:   tgt_idx = 2'd0;
      TGT_Y:   tgt_idx = 2'd1;
      TGT_B:   tgt_idx = 2'd2;
      default: tgt_idx = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_frames <= ARM_RESET;
    end else if (cfg_we) begin
      arm_frames <= cfg_arm_frames;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_counter    <= '0;
      rx_target      <= TGT_IDLE;
      rx_position    <= '0;
      trip_latch     <= 1'b0;
      trip_phase     <= PHASE_NONE;
      indicator_flag <= 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
        remote_lead[p]     <= ASCII_ZERO;
        remote_hundreds[p] <= ASCII_ZERO;
        last_avg[p]        <= '0;
      end
    end else if (en && !trip_latch) begin
      if (kind == KIND_MEASURE) begin
        for (int p = 0; p < NUM_PHASES; p++) last_avg[p] <= lane_res[p].avg;
        indicator_flag <= 1'b1;
        if (arm_counter >= arm_frames && hit_phase != PHASE_NONE) begin
          trip_latch <= 1'b1;
          trip_phase <= hit_phase;
        end
      end else if (rx_target == TGT_IDLE) begin
        case (rx_byte)
          HDR_R: begin
            rx_target      <= TGT_R;
            indicator_flag <= 1'b0;
            rx_position    <= '0;
          end
          HDR_Y: begin
            rx_target      <= TGT_Y;
            indicator_flag <= 1'b0;
            rx_position    <= '0;
          end
          HDR_B: begin
            rx_target      <= TGT_B;
            indicator_flag <= 1'b0;
            rx_position    <= '0;
            if (arm_counter != ARM_MAX) arm_counter <= arm_counter + 2'd1;
          end
          default: ;
        endcase
      end else begin
        if (rx_position == 2'd0) remote_lead[tgt_idx] <= rx_byte;
        if (rx_position == 2'd1) remote_hundreds[tgt_idx] <= rx_byte;
        if (rx_position >= 2'd2) begin
          rx_position <= '0;
          rx_target   <= TGT_IDLE;
        end else begin
          rx_position <= rx_position + 2'd1;
        end
      end
    end
  end

  assign status.tripped   = trip_latch;
  assign status.phase     = trip_phase;
  assign status.indicator = indicator_flag;
  assign status.r_avg     = last_avg[0];
  assign status.y_avg     = last_avg[1];
  assign status.b_avg     = last_avg[2];

endmodule

// ===== design/differential_phase_trip_unit.sv =====
// Top level of the differential phase trip unit: stream ports, lanes, control, output stage.
// Depends on dpt_pkg, dpt_lane and dpt_ctrl.
//
// Usage: each input transaction on s_* is either a local measurement (s_tuser = 0,
// nine 10-bit samples in s_tdata) or one received serial byte (s_tuser = 1).
// Three lanes average each phase and compare its digits with the remote digits
// collected by the frame parser; a merge picks the first faulted phase.
// Every input transaction yields exactly one output transaction on m_* holding
// trip state, relay drives, indicator and the last averages after that item.
// The result is registered and valid in the cycle after acceptance. Throughput: one item per
// cycle while m_tready is high; the loop through the parser/trip state closes in the cycle of acceptance.
// When the receiver stalls, the result holds in the output stage and s_tready
// drops until it is taken; a new item is accepted in the cycle the old result leaves.
// cfg_* writes arm_frames (ready always high); write it only while idle.
// Reset (rst, synchronous): remote digits ASCII zero, counters, latch and
// averages cleared, arm_frames = 2, output stage empty.
module differential_phase_trip_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [9:0] r_sample_one, [19:10] r_sample_two, [29:20] r_sample_three,
  // [39:30] y_sample_one, [49:40] y_sample_two, [59:50] y_sample_three,
  // [69:60] b_sample_one, [79:70] b_sample_two, [89:80] b_sample_three,
  // [97:90] rx_byte, [103:98] zero
  input  logic [103:0] s_tdata,
  // [0] kind
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] tripped, [2:1] faulted_phase, [3] relay_one, [4] relay_two, [5] relay_three,
  // [6] indicator, [16:7] r_average, [26:17] y_average, [36:27] b_average, [39:37] zero
  output logic [39:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data
);
  import dpt_pkg::*;

  logic                en;
  logic [DIGIT_W-1:0]  remote_lead [NUM_PHASES];
  logic [DIGIT_W-1:0]  remote_hundreds [NUM_PHASES];
  lane_res_t           lane_res [NUM_PHASES];
  status_t             status;

  assign s_tready  = !m_tvalid || m_tready;
  assign en        = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  for (genvar p = 0; p < NUM_PHASES; p++) begin : g_lane
    dpt_lane u_lane (
      .sample_one      (s_tdata[(3*p)*SAMPLE_W +: SAMPLE_W]),
      .sample_two      (s_tdata[(3*p+1)*SAMPLE_W +: SAMPLE_W]),
      .sample_three    (s_tdata[(3*p+2)*SAMPLE_W +: SAMPLE_W]),
      .remote_lead     (remote_lead[p]),
      .remote_hundreds (remote_hundreds[p]),
      .res             (lane_res[p])
    );
  end

  dpt_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .kind            (s_tuser),
    .rx_byte         (s_tdata[97:90]),
    .lane_res        (lane_res),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_arm_frames  (cfg_data),
    .remote_lead     (remote_lead),
    .remote_hundreds (remote_hundreds),
    .status          (status)
  );

  // state only moves on acceptance, so it stays stable while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {3'b000, status.b_avg, status.y_avg, status.r_avg, status.indicator,
                    !status.tripped, status.tripped, status.tripped, status.phase,
                    status.tripped};

endmodule
